FILE: rtl/cer_pkg.sv
package cer_pkg;

  localparam int MAX_MEMORY_DEF = 8;

  localparam int MEMORY_ORDER_W = 4;
  localparam int POLY_W         = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_SECOND  = 2'd2;

  localparam int                MEMORY_ORDER_RST = 2;
  localparam logic [POLY_W-1:0] POLY_FIRST_RST   = 9'd7;
  localparam logic [POLY_W-1:0] POLY_SECOND_RST  = 9'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic info_bit;
    logic is_last;
  } item_t;

endpackage

FILE: rtl/cer_if.sv
interface cer_item_if;
  logic valid;
  logic ready;
  logic info_bit;
  logic is_last;

  modport source (output valid, output info_bit, output is_last, input ready);
  modport sink   (input valid, input info_bit, input is_last, output ready);
endinterface

interface cer_code_if;
  logic valid;
  logic ready;
  logic code_first;
  logic code_second;
  logic end_of_codeword;

  modport source (output valid, output code_first, output code_second,
                  output end_of_codeword, input ready);
  modport sink   (input valid, input code_first, input code_second,
                  input end_of_codeword, output ready);
endinterface

interface cer_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cer_pkg::CFG_IDX_W-1:0]  index;
  logic [cer_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/conv_encoder_rate_half.sv
// An input item is written into the queue, popped, and registered as a code pair.
// One input item per cycle while out_o is not stalled; an item marked last holds
// the encoder while its memory_order tail pairs are flushed.
// A 4-entry queue keeps taking items during a flush while it has room.
// Reset: delay line cleared, queue empty, memory_order 2, polynomials 7 and 5.
module conv_encoder_rate_half #(
  parameter int MAX_MEMORY = cer_pkg::MAX_MEMORY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cer_cfg_if.sink     cfg_i,
  cer_item_if.sink    in_i,
  cer_code_if.source  out_o
);

  localparam int LINE_W = MAX_MEMORY + 1;
  localparam int ORD_W  = $clog2(MAX_MEMORY + 1);

  logic              push, q_ready, q_valid, pop, tail_busy;
  cer_pkg::item_t    item, head;
  logic [ORD_W-1:0]  ord;
  logic [LINE_W-1:0] mask, poly_a, poly_b;

  cer_front #(
    .MAX_MEMORY (MAX_MEMORY),
    .LINE_W     (LINE_W),
    .ORD_W      (ORD_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (item),
    .ord_o     (ord),
    .mask_o    (mask),
    .poly_a_o  (poly_a),
    .poly_b_o  (poly_b)
  );

  cer_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  cer_back #(
    .MAX_MEMORY (MAX_MEMORY),
    .LINE_W     (LINE_W),
    .ORD_W      (ORD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .tail_busy_o (tail_busy),
    .ord_i       (ord),
    .mask_i      (mask),
    .poly_a_i    (poly_a),
    .poly_b_i    (poly_b),
    .out_o       (out_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_no_pop_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_busy |-> !pop)
    else $error("item popped during tail flush");

  a_last_starts_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.is_last) |=> tail_busy)
    else $error("last item did not start tail flush");

endmodule

FILE: rtl/cer_front.sv
module cer_front #(
  parameter int MAX_MEMORY = cer_pkg::MAX_MEMORY_DEF,
  parameter int LINE_W     = MAX_MEMORY + 1,
  parameter int ORD_W      = $clog2(MAX_MEMORY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cer_cfg_if.sink             cfg_i,
  cer_item_if.sink            in_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output cer_pkg::item_t      item_o,
  output logic [ORD_W-1:0]    ord_o,
  output logic [LINE_W-1:0]   mask_o,
  output logic [LINE_W-1:0]   poly_a_o,
  output logic [LINE_W-1:0]   poly_b_o
);

  localparam int OrdRst = (MAX_MEMORY < cer_pkg::MEMORY_ORDER_RST) ?
                          MAX_MEMORY : cer_pkg::MEMORY_ORDER_RST;

  logic [ORD_W-1:0]           ord_q, ord_new;
  logic [cer_pkg::POLY_W-1:0] poly_a_q, poly_b_q;
  logic                       cfg_fire;
  logic [cer_pkg::MEMORY_ORDER_W-1:0] mo_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign mo_wr       = cfg_i.data[cer_pkg::MEMORY_ORDER_W-1:0];

  // saturate the order into 1..MAX_MEMORY
  always_comb begin
    if (int'(mo_wr) == 0) begin
      ord_new = ORD_W'(1);
    end else if (int'(mo_wr) > MAX_MEMORY) begin
      ord_new = ORD_W'(MAX_MEMORY);
    end else begin
      ord_new = ORD_W'(mo_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q    <= ORD_W'(OrdRst);
      poly_a_q <= cer_pkg::POLY_FIRST_RST;
      poly_b_q <= cer_pkg::POLY_SECOND_RST;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        cer_pkg::REG_MEMORY_ORDER: ord_q    <= ord_new;
        cer_pkg::REG_POLY_FIRST:   poly_a_q <= cfg_i.data[cer_pkg::POLY_W-1:0];
        cer_pkg::REG_POLY_SECOND:  poly_b_q <= cfg_i.data[cer_pkg::POLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < LINE_W; i++) begin
      mask_o[i] = (i <= int'(ord_q));
      if (i < cer_pkg::POLY_W) begin
        poly_a_o[i] = poly_a_q[i];
        poly_b_o[i] = poly_b_q[i];
      end else begin
        poly_a_o[i] = 1'b0;
        poly_b_o[i] = 1'b0;
      end
    end
  end

  assign ord_o           = ord_q;
  assign in_i.ready      = q_ready_i;
  assign push_o          = in_i.valid && q_ready_i;
  assign item_o.info_bit = in_i.info_bit;
  assign item_o.is_last  = in_i.is_last;

endmodule

FILE: rtl/cer_queue.sv
module cer_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cer_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cer_pkg::item_t head_o
);

  localparam int PW = cer_pkg::QPTR_W;

  cer_pkg::item_t   mem_q [cer_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;

  assign ready_o = (cnt_q != (PW+1)'(cer_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/cer_back.sv
module cer_back #(
  parameter int MAX_MEMORY = cer_pkg::MAX_MEMORY_DEF,
  parameter int LINE_W     = MAX_MEMORY + 1,
  parameter int ORD_W      = $clog2(MAX_MEMORY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cer_pkg::item_t    head_i,
  output logic              pop_o,
  output logic              tail_busy_o,
  input  logic [ORD_W-1:0]  ord_i,
  input  logic [LINE_W-1:0] mask_i,
  input  logic [LINE_W-1:0] poly_a_i,
  input  logic [LINE_W-1:0] poly_b_i,
  cer_code_if.source        out_o
);

  logic [LINE_W-1:0] line_q, line_d, line_sh;
  logic [ORD_W-1:0]  tail_q, tail_d;
  logic              out_valid_q, out_valid_d;
  logic              code_a_q, code_b_q, end_q;
  logic              advance, tail_busy, tail_end, fire, shift_bit;

  assign advance   = !out_valid_q || out_o.ready;
  assign tail_busy = (tail_q != '0);
  assign tail_end  = (tail_q == ORD_W'(1));
  assign pop_o     = advance && !tail_busy && q_valid_i;
  assign fire      = pop_o || (advance && tail_busy);
  assign shift_bit = pop_o ? head_i.info_bit : 1'b0;
  assign line_sh   = {line_q[LINE_W-2:0], shift_bit} & mask_i;

  always_comb begin
    line_d      = line_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (fire) begin
      out_valid_d = 1'b1;
      line_d      = (tail_busy && tail_end) ? '0 : line_sh;
      if (tail_busy) begin
        tail_d = tail_q - ORD_W'(1);
      end else if (head_i.is_last) begin
        tail_d = ord_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_a_q <= ^(poly_a_i & line_sh);
      code_b_q <= ^(poly_b_i & line_sh);
      end_q    <= tail_busy && tail_end;
    end
  end

  assign tail_busy_o           = tail_busy;
  assign out_o.valid           = out_valid_q;
  assign out_o.code_first      = code_a_q;
  assign out_o.code_second     = code_b_q;
  assign out_o.end_of_codeword = end_q;

endmodule

FILE: tb/tb_conv_encoder_rate_half.sv
`timescale 1ns / 1ps

module tb_conv_encoder_rate_half;

  localparam int DL_W        = cer_pkg::MAX_MEMORY_DEF + 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic code_first;
    logic code_second;
    logic end_of_codeword;
  } code_pair_t;

  logic clk_i;
  logic rst_ni;

  cer_cfg_if  cfg_ch ();
  cer_item_if bit_ch ();
  cer_code_if code_ch ();

  conv_encoder_rate_half #(
    .MAX_MEMORY(cer_pkg::MAX_MEMORY_DEF)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (bit_ch),
    .out_o (code_ch)
  );

  cer_pkg::item_t pending_items[$];
  code_pair_t     expected_pairs[$];

  logic [cer_pkg::MEMORY_ORDER_W-1:0] order_q;
  logic [cer_pkg::POLY_W-1:0]         poly_first_q;
  logic [cer_pkg::POLY_W-1:0]         poly_second_q;
  logic [DL_W-1:0]                    model_line;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic encode_item(input logic info_bit, input logic is_last);
    int unsigned     order;
    logic [DL_W-1:0] mask;
    code_pair_t      pair;
    order = order_q;
    if (order < 1) order = 1;
    if (order > cer_pkg::MAX_MEMORY_DEF) order = cer_pkg::MAX_MEMORY_DEF;
    mask = DL_W'((1 << (order + 1)) - 1);
    for (int k = 0; k <= order; k++) begin
      model_line = {model_line[DL_W-2:0], (k == 0) ? info_bit : 1'b0} & mask;
      pair.code_first      = ^(poly_first_q & model_line);
      pair.code_second     = ^(poly_second_q & model_line);
      pair.end_of_codeword = is_last && (k == order);
      expected_pairs.push_back(pair);
      if (!is_last) break;
    end
    if (is_last) model_line = '0;
  endtask

  // input side: drive pending items and predict on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ch.valid <= 1'b0;
    end else begin
      if (bit_ch.valid && bit_ch.ready) begin
        encode_item(bit_ch.info_bit, bit_ch.is_last);
      end
      if (!bit_ch.valid || bit_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bit_ch.valid    <= 1'b1;
          bit_ch.info_bit <= pending_items[0].info_bit;
          bit_ch.is_last  <= pending_items[0].is_last;
          void'(pending_items.pop_front());
        end else begin
          bit_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output side: stall at random and check each code pair
  always @(posedge clk_i or negedge rst_ni) begin
    code_pair_t want;
    if (!rst_ni) begin
      code_ch.ready <= 1'b0;
    end else begin
      if (code_ch.valid && code_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("[%0t] unexpected code pair: first %b second %b end %b", $time,
                     code_ch.code_first, code_ch.code_second, code_ch.end_of_codeword);
        end else begin
          want = expected_pairs.pop_front();
          if (want.code_first !== code_ch.code_first ||
              want.code_second !== code_ch.code_second ||
              want.end_of_codeword !== code_ch.end_of_codeword) begin
            error_count++;
            if (error_count <= 10)
              $display("[%0t] code pair mismatch: expected %b/%b/%b got %b/%b/%b", $time,
                       want.code_first, want.code_second, want.end_of_codeword,
                       code_ch.code_first, code_ch.code_second, code_ch.end_of_codeword);
          end
        end
      end
      code_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(input logic info_bit, input logic is_last);
    cer_pkg::item_t it;
    it.info_bit = info_bit;
    it.is_last  = is_last;
    pending_items.push_back(it);
  endtask

  task automatic add_message(input logic [7:0] bits, input int len);
    for (int i = 0; i < len; i++) add_item(bits[i], i == len - 1);
  endtask

  task automatic add_random_message(input int len);
    for (int i = 0; i < len; i++) add_item($urandom_range(1), i == len - 1);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || bit_ch.valid || expected_pairs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cer_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      cer_pkg::REG_MEMORY_ORDER: order_q       = data[cer_pkg::MEMORY_ORDER_W-1:0];
      cer_pkg::REG_POLY_FIRST:   poly_first_q  = data[cer_pkg::POLY_W-1:0];
      cer_pkg::REG_POLY_SECOND:  poly_second_q = data[cer_pkg::POLY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [cer_pkg::MEMORY_ORDER_W-1:0] order,
                           input logic [cer_pkg::POLY_W-1:0] poly_a,
                           input logic [cer_pkg::POLY_W-1:0] poly_b);
    write_reg(cer_pkg::REG_MEMORY_ORDER, cer_pkg::CFG_DATA_W'(order));
    write_reg(cer_pkg::REG_POLY_FIRST, cer_pkg::CFG_DATA_W'(poly_a));
    write_reg(cer_pkg::REG_POLY_SECOND, cer_pkg::CFG_DATA_W'(poly_b));
  endtask

  initial begin
    int count;
    int len;
    rst_ni          = 1'b0;
    bit_ch.valid    = 1'b0;
    bit_ch.info_bit = 1'b0;
    bit_ch.is_last  = 1'b0;
    code_ch.ready   = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    order_q         = cer_pkg::MEMORY_ORDER_W'(cer_pkg::MEMORY_ORDER_RST);
    poly_first_q    = cer_pkg::POLY_FIRST_RST;
    poly_second_q   = cer_pkg::POLY_SECOND_RST;
    model_line      = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    cycle_count     = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(4'd2, 9'd7, 9'd5);
    add_message(8'b0000_0001, 1);
    add_message(8'b0000_1101, 4);
    drain();

    configure(4'd0, 9'h1FF, 9'h000);
    add_message(8'b0000_0011, 3);
    add_message(8'b0000_0000, 1);
    drain();

    configure(4'd8, 9'h100, 9'h0FF);
    add_message(8'b0001_1001, 5);
    drain();

    // hold a message open across an order change
    configure(4'd15, 9'h1FF, 9'h0AB);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b0);
    drain();
    configure(4'd1, 9'h003, 9'h002);
    add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int s = 0; s < 2; s++) begin
        if (s == 0) begin
          case (p)
            0: configure(4'd8, 9'h1FF, 9'h155);
            1: configure(4'd0, 9'h000, 9'h1FF);
            2: configure(4'd15, 9'h1FF, 9'h1FF);
            default: configure(4'd1, 9'h001, 9'h002);
          endcase
        end else begin
          configure(cer_pkg::MEMORY_ORDER_W'($urandom_range(15)),
                    cer_pkg::POLY_W'($urandom_range(511)),
                    cer_pkg::POLY_W'($urandom_range(511)));
        end
        count = 0;
        while (count < 30) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
          add_random_message(len);
          count += len;
        end
        drain();
      end
    end

    if (expected_pairs.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cer_pkg.sv
rtl/cer_if.sv
rtl/cer_front.sv
rtl/cer_queue.sv
rtl/cer_back.sv
rtl/conv_encoder_rate_half.sv
tb/tb_conv_encoder_rate_half.sv
